// File: rtl/drive_mode_selector_core_defines.svh
// assertion macros for the drive mode selector checker
// used by dms_checker.sv, no other dependencies
`ifndef DRIVE_MODE_SELECTOR_CORE_DEFINES_SVH
`define DRIVE_MODE_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define DMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drive mode selector check failed");

// next-cycle implication, off while reset is asserted
`define DMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drive mode selector check failed");

`endif

// File: rtl/dms_pkg.sv
// shared types and codes for the drive mode selector
// no dependencies
`timescale 1ns / 1ps

package dms_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_VELOCITY = 2'd1;
    localparam logic [1:0] CMD_CURRENT  = 2'd2;

    // mode codes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NEUTRAL = 3'd1;
    localparam logic [2:0] MODE_REVERSE = 3'd2;
    localparam logic [2:0] MODE_BRAKE   = 3'd3;
    localparam logic [2:0] MODE_DRIVE   = 3'd4;
    localparam logic [2:0] MODE_PLUGIN  = 3'd5;

    // gear led bits
    localparam logic [3:0] LED_DRIVE   = 4'b0001;
    localparam logic [3:0] LED_BRAKE   = 4'b0010;
    localparam logic [3:0] LED_NEUTRAL = 4'b0100;
    localparam logic [3:0] LED_REVERSE = 4'b1000;

    // configuration register indexes
    localparam logic [1:0] CFG_FORWARD_SPEED = 2'd0;
    localparam logic [1:0] CFG_REVERSE_SPEED = 2'd1;
    localparam logic [1:0] CFG_REGEN_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_FLASH_HALF    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values
    localparam logic signed [15:0] FORWARD_SPEED_RESET = 16'sd256;
    localparam logic signed [15:0] REVERSE_SPEED_RESET = -16'sd256;
    localparam logic signed [15:0] REGEN_LIMIT_RESET   = -16'sd256;
    localparam logic [6:0]         FLASH_HALF_RESET    = 7'd25;

    typedef struct packed {
        logic signed [15:0] forward_engage_speed;
        logic signed [15:0] reverse_engage_speed;
        logic signed [15:0] regen_current_limit;
        logic [6:0]         flash_half_period;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] sample;
        logic               ign_on;
        logic               fuel_door;
        logic               sel_reverse;
        logic               sel_neutral;
        logic               sel_brake_mode;
        logic               sel_drive;
        logic               brake_pedal;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       moving_forward;
        logic       moving_reverse;
        logic       moving_slow;
        logic       regen_active;
        logic [7:0] flash_count;
        logic [3:0] led;
        logic       last_brake;
        logic       last_ign;
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] gear_leds;
        logic       brake_light;
        logic       reverse_light;
        logic       drive_zero;
    } result_t;

endpackage

// File: rtl/drive_mode_selector_core.sv
// an accepted input transaction goes through the input register, then the result register
// throughput: one transaction per cycle unless the output stalls, set by the state loop
// the mode/flag state is updated in the same cycle the result register is loaded
// reset: asynchronous active low, returns mode to off, clears flags and leds,
// loads the configuration registers and flash counter with their defaults
`timescale 1ns / 1ps

module drive_mode_selector_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write_en,
    input  logic [dms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic signed [15:0]              sample,
    input  logic                            ign_on,
    input  logic                            fuel_door,
    input  logic                            sel_reverse,
    input  logic                            sel_neutral,
    input  logic                            sel_brake_mode,
    input  logic                            sel_drive,
    input  logic                            brake_pedal,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      mode,
    output logic [3:0]                      gear_leds,
    output logic                            brake_light,
    output logic                            reverse_light,
    output logic                            drive_zero
);
    import dms_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // input stage: holds one accepted transaction
    logic    in_valid_reg;
    item_t   item_reg;
    item_t   item_in;

    // architectural state, advanced when the input stage hands off
    state_t  state_reg;
    state_t  state_next;

    // result stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic    advance;

    // the input stage moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign item_in.command        = command;
    assign item_in.sample         = sample;
    assign item_in.ign_on         = ign_on;
    assign item_in.fuel_door      = fuel_door;
    assign item_in.sel_reverse    = sel_reverse;
    assign item_in.sel_neutral    = sel_neutral;
    assign item_in.sel_brake_mode = sel_brake_mode;
    assign item_in.sel_drive      = sel_drive;
    assign item_in.brake_pedal    = brake_pedal;

    // configuration writes land directly, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward_engage_speed <= FORWARD_SPEED_RESET;
            cfg_reg.reverse_engage_speed <= REVERSE_SPEED_RESET;
            cfg_reg.regen_current_limit  <= REGEN_LIMIT_RESET;
            cfg_reg.flash_half_period    <= FLASH_HALF_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FORWARD_SPEED: cfg_reg.forward_engage_speed <= cfg_data;
                CFG_REVERSE_SPEED: cfg_reg.reverse_engage_speed <= cfg_data;
                CFG_REGEN_LIMIT:   cfg_reg.regen_current_limit  <= cfg_data;
                CFG_FLASH_HALF:    cfg_reg.flash_half_period    <= cfg_data[6:0];
                default:           cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    // mode transitions, flag updates and result fields
    dms_next_state u_next_state (
        .cur  (state_reg),
        .item (item_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= MODE_IDLE;
            state_reg.moving_forward <= 1'b0;
            state_reg.moving_reverse <= 1'b0;
            state_reg.moving_slow    <= 1'b0;
            state_reg.regen_active   <= 1'b0;
            state_reg.flash_count    <= {1'b0, FLASH_HALF_RESET};
            state_reg.led            <= '0;
            state_reg.last_brake     <= 1'b0;
            state_reg.last_ign       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register, one result per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = result_reg.mode;
    assign gear_leds     = result_reg.gear_leds;
    assign brake_light   = result_reg.brake_light;
    assign reverse_light = result_reg.reverse_light;
    assign drive_zero    = result_reg.drive_zero;

endmodule

// File: rtl/dms_next_state.sv
// next-state and result logic for one transaction of the drive mode selector
// depends on dms_pkg
`timescale 1ns / 1ps

module dms_next_state (
    input  dms_pkg::state_t  cur,
    input  dms_pkg::item_t   item,
    input  dms_pkg::cfg_t    cfg,
    output dms_pkg::state_t  nxt,
    output dms_pkg::result_t res
);
    import dms_pkg::*;

    logic       ok_fwd;
    logic       ok_rev;
    logic [7:0] fc_dec;
    logic [2:0] tick_mode;
    logic [3:0] tick_led;
    logic [7:0] tick_fc;

    assign ok_fwd = cur.moving_slow | cur.moving_forward;
    assign ok_rev = cur.moving_slow | cur.moving_reverse;
    assign fc_dec = cur.flash_count - 8'd1;

    // mode transitions by priority, leds show the mode held before the tick
    always_comb
    begin
        tick_mode = MODE_IDLE;
        tick_led  = cur.led;
        tick_fc   = cur.flash_count;
        unique case (cur.mode)
            MODE_IDLE:
            begin
                tick_mode = item.ign_on ? MODE_NEUTRAL : MODE_IDLE;
                tick_led  = '0;
            end
            MODE_NEUTRAL:
            begin
                priority if (item.sel_reverse && ok_rev)   tick_mode = MODE_REVERSE;
                else if (item.sel_brake_mode && ok_fwd)    tick_mode = MODE_BRAKE;
                else if (item.sel_drive && ok_fwd)         tick_mode = MODE_DRIVE;
                else if (!item.ign_on)                     tick_mode = MODE_IDLE;
                else if (item.fuel_door)                   tick_mode = MODE_PLUGIN;
                else                                       tick_mode = MODE_NEUTRAL;
                tick_led = LED_NEUTRAL;
            end
            MODE_REVERSE:
            begin
                priority if (item.sel_neutral)             tick_mode = MODE_NEUTRAL;
                else if (item.sel_brake_mode && ok_fwd)    tick_mode = MODE_BRAKE;
                else if (item.sel_drive && ok_fwd)         tick_mode = MODE_DRIVE;
                else if (!item.ign_on)                     tick_mode = MODE_IDLE;
                else if (item.fuel_door)                   tick_mode = MODE_PLUGIN;
                else                                       tick_mode = MODE_REVERSE;
                tick_led = LED_REVERSE;
            end
            MODE_BRAKE:
            begin
                priority if (item.sel_neutral)             tick_mode = MODE_NEUTRAL;
                else if (item.sel_reverse && ok_rev)       tick_mode = MODE_REVERSE;
                else if (item.sel_drive && ok_fwd)         tick_mode = MODE_DRIVE;
                else if (!item.ign_on)                     tick_mode = MODE_IDLE;
                else if (item.fuel_door)                   tick_mode = MODE_PLUGIN;
                else                                       tick_mode = MODE_BRAKE;
                tick_led = LED_BRAKE;
            end
            MODE_DRIVE:
            begin
                priority if (item.sel_neutral)             tick_mode = MODE_NEUTRAL;
                else if (item.sel_brake_mode && ok_fwd)    tick_mode = MODE_BRAKE;
                else if (item.sel_reverse && ok_rev)       tick_mode = MODE_REVERSE;
                else if (!item.ign_on)                     tick_mode = MODE_IDLE;
                else if (item.fuel_door)                   tick_mode = MODE_PLUGIN;
                else                                       tick_mode = MODE_DRIVE;
                tick_led = LED_DRIVE;
            end
            MODE_PLUGIN:
            begin
                priority if (!item.fuel_door)              tick_mode = MODE_NEUTRAL;
                else if (!item.ign_on)                     tick_mode = MODE_IDLE;
                else                                       tick_mode = MODE_PLUGIN;
                // neutral led flashes on the countdown
                tick_fc  = fc_dec;
                tick_led = cur.led & LED_NEUTRAL;
                priority if (fc_dec == 8'd0)
                begin
                    tick_fc  = {cfg.flash_half_period, 1'b0};
                    tick_led = tick_led | LED_NEUTRAL;
                end
                else if (fc_dec == {1'b0, cfg.flash_half_period})
                begin
                    tick_led = tick_led & ~LED_NEUTRAL;
                end
            end
            default:
            begin
                tick_mode = MODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        nxt = cur;
        unique case (item.command)
            CMD_TICK:
            begin
                nxt.mode        = tick_mode;
                nxt.led         = tick_led;
                nxt.flash_count = tick_fc;
                nxt.last_ign    = item.ign_on;
                nxt.last_brake  = item.brake_pedal;
            end
            CMD_VELOCITY:
            begin
                nxt.moving_forward = item.sample > cfg.forward_engage_speed;
                nxt.moving_reverse = item.sample < cfg.reverse_engage_speed;
                nxt.moving_slow    = (item.sample >= cfg.reverse_engage_speed) &&
                                     (item.sample <= cfg.forward_engage_speed);
            end
            CMD_CURRENT:
            begin
                nxt.regen_active = item.sample < cfg.regen_current_limit;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.mode          = nxt.mode;
        res.gear_leds     = nxt.led;
        res.brake_light   = nxt.last_brake | nxt.regen_active;
        res.reverse_light = (nxt.mode == MODE_REVERSE);
        res.drive_zero    = !(nxt.last_ign && !nxt.last_brake &&
                              ((nxt.mode == MODE_REVERSE) || (nxt.mode == MODE_BRAKE) ||
                               (nxt.mode == MODE_DRIVE)));
    end

endmodule

// File: rtl/dms_checker.sv
// port-level checks on the drive mode selector, bound to the top level
// depends on dms_pkg and drive_mode_selector_core_defines.svh
`timescale 1ns / 1ps
`include "drive_mode_selector_core_defines.svh"

module dms_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [2:0]                      mode,
    input logic                            reverse_light,
    input logic                            drive_zero
);
    import dms_pkg::*;

    // reverse light tracks the reported mode
    `DMS_ASSERT_IMPLY(a_rev_light, clk, rst_n, out_valid, reverse_light == (mode == MODE_REVERSE))

    // torque only enabled in a driving mode
    `DMS_ASSERT_IMPLY(a_drive_mode, clk, rst_n, out_valid && !drive_zero, (mode == MODE_REVERSE) || (mode == MODE_BRAKE) || (mode == MODE_DRIVE))

    // the off mode never releases the drive
    `DMS_ASSERT_IMPLY(a_off_zero, clk, rst_n, out_valid && (mode == MODE_IDLE), drive_zero)

    // a stalled result holds its mode
    `DMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mode))

endmodule

bind drive_mode_selector_core dms_checker u_dms_checker (.*);

// File: tb/drive_mode_selector_core_tb.sv
// self-checking bench for the drive mode selector core: random switch and report traffic
// against an in-bench dashboard predictor, several threshold and flash settings
// depends on rtl/dms_pkg.sv and rtl/drive_mode_selector_core.sv
`timescale 1ns / 1ps

module drive_mode_selector_core_tb;

    import dms_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int STALL_LIMIT = 2000;     // cycles with no transaction before giving up
    localparam int HOLD_CYCLES = 400;      // long output back-pressure stretch
    localparam int HOLD_AFTER = 700;       // results seen before the long hold starts
    localparam int PHASE_ITEMS = 250;      // random transactions per setting
    localparam int PRINT_CAP = 60;         // mismatch lines printed at most
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    // clock, reset and dut ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = CMD_TICK;
    logic signed [15:0] sample = '0;
    logic ign_on = 1'b0;
    logic fuel_door = 1'b0;
    logic sel_reverse = 1'b0;
    logic sel_neutral = 1'b0;
    logic sel_brake_mode = 1'b0;
    logic sel_drive = 1'b0;
    logic brake_pedal = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] mode;
    logic [3:0] gear_leds;
    logic brake_light;
    logic reverse_light;
    logic drive_zero;

    drive_mode_selector_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .sample         (sample),
        .ign_on         (ign_on),
        .fuel_door      (fuel_door),
        .sel_reverse    (sel_reverse),
        .sel_neutral    (sel_neutral),
        .sel_brake_mode (sel_brake_mode),
        .sel_drive      (sel_drive),
        .brake_pedal    (brake_pedal),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mode           (mode),
        .gear_leds      (gear_leds),
        .brake_light    (brake_light),
        .reverse_light  (reverse_light),
        .drive_zero     (drive_zero)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // commands waiting to be offered, dashboard results waiting to come out
    item_t cmd_q[$];
    result_t dash_q[$];
    item_t cur_cmd;
    result_t want;
    int error_count = 0;
    int dash_count = 0;

    // predictor copy of the thresholds
    logic signed [15:0] c_fwd;
    logic signed [15:0] c_rev;
    logic signed [15:0] c_regen;
    logic [6:0] c_half;

    // predictor copy of the selector state
    logic [2:0] m_mode;
    logic m_fwd, m_rev, m_slow, m_regen;
    logic [7:0] m_flash;
    logic [3:0] m_led;
    logic m_brake, m_ign;

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t mismatch on %s: expected %0d got %0d", $realtime, what, want_v, got_v);
    endtask

    // applies one transaction to the predicted state, returns the dashboard it shows
    function automatic result_t predict_dash(item_t it);
        result_t r;
        logic [2:0] nx;
        logic okf, okr, driving;
        logic signed [15:0] s;
        s = it.sample;
        okf = m_slow | m_fwd;
        okr = m_slow | m_rev;
        nx = MODE_IDLE;
        case (it.command)
            CMD_TICK:
            begin
                // leds follow the mode held before the tick
                case (m_mode)
                    MODE_IDLE:
                    begin
                        nx = it.ign_on ? MODE_NEUTRAL : MODE_IDLE;
                        m_led = '0;
                    end
                    MODE_NEUTRAL:
                    begin
                        if (it.sel_reverse && okr) nx = MODE_REVERSE;
                        else if (it.sel_brake_mode && okf) nx = MODE_BRAKE;
                        else if (it.sel_drive && okf) nx = MODE_DRIVE;
                        else if (!it.ign_on) nx = MODE_IDLE;
                        else if (it.fuel_door) nx = MODE_PLUGIN;
                        else nx = MODE_NEUTRAL;
                        m_led = LED_NEUTRAL;
                    end
                    MODE_REVERSE:
                    begin
                        if (it.sel_neutral) nx = MODE_NEUTRAL;
                        else if (it.sel_brake_mode && okf) nx = MODE_BRAKE;
                        else if (it.sel_drive && okf) nx = MODE_DRIVE;
                        else if (!it.ign_on) nx = MODE_IDLE;
                        else if (it.fuel_door) nx = MODE_PLUGIN;
                        else nx = MODE_REVERSE;
                        m_led = LED_REVERSE;
                    end
                    MODE_BRAKE:
                    begin
                        if (it.sel_neutral) nx = MODE_NEUTRAL;
                        else if (it.sel_reverse && okr) nx = MODE_REVERSE;
                        else if (it.sel_drive && okf) nx = MODE_DRIVE;
                        else if (!it.ign_on) nx = MODE_IDLE;
                        else if (it.fuel_door) nx = MODE_PLUGIN;
                        else nx = MODE_BRAKE;
                        m_led = LED_BRAKE;
                    end
                    MODE_DRIVE:
                    begin
                        if (it.sel_neutral) nx = MODE_NEUTRAL;
                        else if (it.sel_brake_mode && okf) nx = MODE_BRAKE;
                        else if (it.sel_reverse && okr) nx = MODE_REVERSE;
                        else if (!it.ign_on) nx = MODE_IDLE;
                        else if (it.fuel_door) nx = MODE_PLUGIN;
                        else nx = MODE_DRIVE;
                        m_led = LED_DRIVE;
                    end
                    MODE_PLUGIN:
                    begin
                        if (!it.fuel_door) nx = MODE_NEUTRAL;
                        else if (!it.ign_on) nx = MODE_IDLE;
                        else nx = MODE_PLUGIN;
                        // neutral led flashes on the wrapping 8-bit counter
                        m_flash = m_flash - 8'd1;
                        m_led = m_led & LED_NEUTRAL;
                        if (m_flash == 8'd0)
                        begin
                            m_flash = {c_half, 1'b0};
                            m_led = m_led | LED_NEUTRAL;
                        end
                        else if (m_flash == {1'b0, c_half})
                            m_led = m_led & ~LED_NEUTRAL;
                    end
                    default: nx = MODE_IDLE;
                endcase
                m_mode = nx;
                m_ign = it.ign_on;
                m_brake = it.brake_pedal;
            end
            CMD_VELOCITY:
            begin
                m_fwd = s > c_fwd;
                m_rev = s < c_rev;
                m_slow = (s >= c_rev) && (s <= c_fwd);
            end
            CMD_CURRENT: m_regen = s < c_regen;
            default: ;
        endcase
        driving = m_ign && (m_mode inside {MODE_REVERSE, MODE_BRAKE, MODE_DRIVE}) && !m_brake;
        r.mode = m_mode;
        r.gear_leds = m_led;
        r.brake_light = m_brake | m_regen;
        r.reverse_light = (m_mode == MODE_REVERSE);
        r.drive_zero = !driving;
        return r;
    endfunction

    // ---------------- stimulus builders ----------------

    function automatic void push_tick(input logic ign, input logic fuel, input logic sr,
                                      input logic sn, input logic sb, input logic sd,
                                      input logic bp);
        item_t it;
        it.command = CMD_TICK;
        it.sample = 16'($urandom);      // don't care on a tick, random anyway
        it.ign_on = ign;
        it.fuel_door = fuel;
        it.sel_reverse = sr;
        it.sel_neutral = sn;
        it.sel_brake_mode = sb;
        it.sel_drive = sd;
        it.brake_pedal = bp;
        cmd_q.push_back(it);
    endfunction

    function automatic void push_report(input logic [1:0] cmd, input logic signed [15:0] s);
        item_t it;
        it = item_t'(25'($urandom));    // switch bits are don't care on a report
        it.command = cmd;
        it.sample = s;
        cmd_q.push_back(it);
    endfunction

    // a sample that lands on, beside or far from a threshold
    function automatic logic signed [15:0] pick_sample(input logic signed [15:0] thr);
        case ($urandom_range(0, 6))
            0: return thr - 16'sd1;
            1: return thr;
            2: return thr + 16'sd1;
            3: return 16'($urandom);
            4: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return thr + 16'($urandom_range(0, 600)) - 16'sd300;
        endcase
    endfunction

    // tick with a mostly one-hot gear selector
    function automatic void push_rand_tick(input logic ign, input logic fuel);
        logic [3:0] sel;
        case ($urandom_range(0, 5))
            0: sel = 4'b0000;
            1: sel = 4'b1000;
            2: sel = 4'b0100;
            3: sel = 4'b0010;
            4: sel = 4'b0001;
            default: sel = 4'($urandom);
        endcase
        push_tick(ign, fuel, sel[3], sel[2], sel[1], sel[0], 1'($urandom));
    endfunction

    function automatic void push_report_rand();
        if ($urandom_range(0, 1) != 0)
            push_report(CMD_VELOCITY, pick_sample(($urandom_range(0, 1) != 0) ? c_fwd : c_rev));
        else
            push_report(CMD_CURRENT, pick_sample(c_regen));
    endfunction

    // one well-formed drive or charge session, or a short burst of noise
    function automatic void push_session();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                // ignition on, speed report, then gear changes with reports mixed in
                push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom));
                push_report(CMD_VELOCITY, pick_sample(($urandom_range(0, 1) != 0) ? c_fwd : c_rev));
                n = $urandom_range(2, 12);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) != 0)
                        push_rand_tick($urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
                    else
                        push_report_rand();
                end
                if ($urandom_range(0, 2) == 0)
                    push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom));
            end
            4, 5, 6:
            begin
                // into charge mode and sit there long enough to flash
                push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom));
                push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom));
                n = $urandom_range(4, 60);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        push_report_rand();
                    else
                        push_rand_tick(1'b1, 1'b1);
                end
                push_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, 1'b0, 1'b0,
                          1'b0, 1'b0, 1'($urandom));
            end
            default:
            begin
                // raw noise, any command code and any bits
                n = $urandom_range(1, 6);
                repeat (n)
                    cmd_q.push_back(item_t'(25'($urandom)));
            end
        endcase
    endfunction

    // ---------------- configuration ----------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // all four registers, only called with nothing in flight
    task automatic apply_cfg(input logic signed [15:0] fwd, input logic signed [15:0] rev,
                             input logic signed [15:0] regen, input logic [6:0] half);
        logic [15:0] half_word;
        half_word = {9'($urandom), half};   // upper bits are unused by the register
        write_reg(CFG_FORWARD_SPEED, fwd);
        write_reg(CFG_REVERSE_SPEED, rev);
        write_reg(CFG_REGEN_LIMIT, regen);
        write_reg(CFG_FLASH_HALF, half_word);
        c_fwd = fwd;
        c_rev = rev;
        c_regen = regen;
        c_half = half_word[6:0];
    endtask

    // waits until nothing is queued, offered or owed, then lets the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || dash_q.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    // ---------------- driver: bursts with random gaps ----------------

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // accepted transaction goes straight through the predictor
            if (in_valid && in_ready)
                dash_q.push_back(predict_dash(cur_cmd));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    command <= cur_cmd.command;
                    sample <= cur_cmd.sample;
                    ign_on <= cur_cmd.ign_on;
                    fuel_door <= cur_cmd.fuel_door;
                    sel_reverse <= cur_cmd.sel_reverse;
                    sel_neutral <= cur_cmd.sel_neutral;
                    sel_brake_mode <= cur_cmd.sel_brake_mode;
                    sel_drive <= cur_cmd.sel_drive;
                    brake_pedal <= cur_cmd.brake_pedal;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // new burst; a third of them follow on with no gap
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver: stall pattern plus one long hold ----------------

    int rx_style = 0;
    int rx_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && dash_count >= HOLD_AFTER)
        begin
            // long hold while the sender keeps offering, fills the pipe
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_style <= $urandom_range(0, 2);
                rx_left <= $urandom_range(5, 60);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_style)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom);
                default: out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ---------------- monitor: field-by-field compare ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            dash_count <= dash_count + 1;
            if (dash_q.size() == 0)
                report_mismatch("result with nothing pending", 32'd0, 32'(mode));
            else
            begin
                want = dash_q.pop_front();
                if (mode !== want.mode)
                    report_mismatch("mode", 32'(want.mode), 32'(mode));
                if (gear_leds !== want.gear_leds)
                    report_mismatch("gear_leds", 32'(want.gear_leds), 32'(gear_leds));
                if (brake_light !== want.brake_light)
                    report_mismatch("brake_light", 32'(want.brake_light), 32'(brake_light));
                if (reverse_light !== want.reverse_light)
                    report_mismatch("reverse_light", 32'(want.reverse_light),
                                    32'(reverse_light));
                if (drive_zero !== want.drive_zero)
                    report_mismatch("drive_zero", 32'(want.drive_zero), 32'(drive_zero));
            end
        end
    end

    // ---------------- watchdog ----------------

    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        // predictor starts from the reset state
        c_fwd = FORWARD_SPEED_RESET;
        c_rev = REVERSE_SPEED_RESET;
        c_regen = REGEN_LIMIT_RESET;
        c_half = FLASH_HALF_RESET;
        m_mode = MODE_IDLE;
        m_fwd = 1'b0;
        m_rev = 1'b0;
        m_slow = 1'b0;
        m_regen = 1'b0;
        m_flash = {1'b0, FLASH_HALF_RESET};
        m_led = '0;
        m_brake = 1'b0;
        m_ign = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, reset thresholds
        push_report(CMD_IGNORED, 16'sh7fff);               // unused command code
        push_report(CMD_VELOCITY, 16'sh8000);              // most negative speed
        push_report(CMD_VELOCITY, 16'sh7fff);              // most positive speed
        push_report(CMD_VELOCITY, 16'sd256);               // on the forward threshold
        push_report(CMD_VELOCITY, -16'sd257);              // just past reverse threshold
        push_report(CMD_CURRENT, 16'sh8000);               // regen on
        push_report(CMD_CURRENT, -16'sd256);               // on the regen limit
        push_report(CMD_CURRENT, 16'sh7fff);
        push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // stays off
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // off to neutral
        push_report(CMD_VELOCITY, 16'sd0);                 // slow
        push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // reverse
        push_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // back to neutral
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // brake mode
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);  // drive
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);  // pedal forces drive zero
        push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // ignition off
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_report(CMD_VELOCITY, 16'sd257);               // forward only
        push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // reverse refused while moving
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // charge
        push_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);  // selectors ignored in charge
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // charge to off
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_report(CMD_CURRENT, -16'sd257);               // regen lights the brake light
        wait_drained();

        // extremes: widest slow band, fastest flash
        apply_cfg(16'sh7fff, 16'sh8000, 16'sh8000, 7'd1);
        while (cmd_q.size() < PHASE_ITEMS) push_session();
        wait_drained();

        // extremes the other way: inverted band, slowest flash
        apply_cfg(16'sh8000, 16'sh7fff, 16'sh7fff, 7'd127);
        while (cmd_q.size() < PHASE_ITEMS) push_session();
        wait_drained();

        // zero half period, counter reloads to zero and wraps
        apply_cfg(16'sd256, -16'sd256, -16'sd256, 7'd0);
        while (cmd_q.size() < PHASE_ITEMS) push_session();
        wait_drained();

        // random settings, mostly short flash periods
        repeat (4)
        begin
            apply_cfg(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : -16'($urandom_range(0, 2048)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : -16'($urandom_range(0, 2048)),
                      ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 127))
                                                  : 7'($urandom_range(1, 6)));
            while (cmd_q.size() < PHASE_ITEMS) push_session();
            wait_drained();
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dms_pkg.sv
rtl/dms_next_state.sv
rtl/drive_mode_selector_core.sv
rtl/dms_checker.sv
tb/drive_mode_selector_core_tb.sv
